// File: rtl/core/jmc_pkg.sv
package jmc_pkg;

    // Step counter and control store
    localparam int STEP_W = 3;

    localparam logic [STEP_W-1:0] STEP_WAIT   = 3'd0;
    localparam logic [STEP_W-1:0] STEP_CHECK  = 3'd1;
    localparam logic [STEP_W-1:0] STEP_SETUP  = 3'd2;
    localparam logic [STEP_W-1:0] STEP_DIV    = 3'd3;
    localparam logic [STEP_W-1:0] STEP_PUSH   = 3'd4;
    localparam logic [STEP_W-1:0] STEP_NEXT   = 3'd5;
    localparam logic [STEP_W-1:0] STEP_BUTTON = 3'd6;
    localparam logic [STEP_W-1:0] STEP_OUT    = 3'd7;

    typedef enum logic [2:0] {
        OP_ACCEPT,
        OP_NOP,
        OP_SETUP,
        OP_DIV,
        OP_PUSH_CC,
        OP_NEXT_AXIS,
        OP_BUTTON,
        OP_OUT
    } t_op;

    typedef enum logic [2:0] {
        C_NEVER,
        C_NO_INPUT,
        C_NO_SCAN,
        C_NO_SEND,
        C_DIV_MORE,
        C_AXIS_ZERO,
        C_OUT_MORE
    } t_cond;

    typedef struct packed {
        t_op               op;
        t_cond             cond;
        logic [STEP_W-1:0] target;
    } t_uword;

    // Message kinds
    localparam logic [1:0] KIND_CC       = 2'd0;
    localparam logic [1:0] KIND_NOTE_ON  = 2'd1;
    localparam logic [1:0] KIND_NOTE_OFF = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic [6:0] number;
        logic [6:0] value;
    } t_msg;

    // Register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CC_NUMBER_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CC_NUMBER_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NOTE_NUMBER = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_PERIOD = 3'd5;

    // Register reset values
    localparam logic [6:0] RST_CENTER_X    = 7'd64;
    localparam logic [6:0] RST_CENTER_Y    = 7'd64;
    localparam logic [6:0] RST_CC_NUMBER_X = 7'd0;
    localparam logic [6:0] RST_CC_NUMBER_Y = 7'd1;
    localparam logic [6:0] RST_NOTE_NUMBER = 7'd60;
    localparam logic [7:0] RST_SCAN_PERIOD = 8'd5;

    // Scaling constants
    localparam int         NUM_W          = 13;
    localparam logic [3:0] DIV_LAST_STEP  = 4'(NUM_W - 1);
    localparam logic [7:0] DEAD_BAND      = 8'd2;
    localparam logic [6:0] FULL_SCALE     = 7'd127;
    localparam logic [6:0] OFFSET_HIGH    = 7'd65;
    localparam logic [6:0] OFFSET_RETURN  = 7'd63;
    localparam logic [6:0] VELOCITY_ON    = 7'd127;
    localparam logic [6:0] VELOCITY_OFF   = 7'd0;
    localparam logic [7:0] SCAN_CNT_MAX   = 8'd255;

    // Control program, one word per step
    function automatic t_uword ucode(input logic [STEP_W-1:0] step);
        t_uword w;
        w = '{op: OP_NOP, cond: C_NEVER, target: STEP_WAIT};
        case (step)
            STEP_WAIT:   w = '{op: OP_ACCEPT,    cond: C_NO_INPUT,  target: STEP_WAIT};
            STEP_CHECK:  w = '{op: OP_NOP,       cond: C_NO_SCAN,   target: STEP_BUTTON};
            STEP_SETUP:  w = '{op: OP_SETUP,     cond: C_NO_SEND,   target: STEP_NEXT};
            STEP_DIV:    w = '{op: OP_DIV,       cond: C_DIV_MORE,  target: STEP_DIV};
            STEP_PUSH:   w = '{op: OP_PUSH_CC,   cond: C_NEVER,     target: STEP_WAIT};
            STEP_NEXT:   w = '{op: OP_NEXT_AXIS, cond: C_AXIS_ZERO, target: STEP_SETUP};
            STEP_BUTTON: w = '{op: OP_BUTTON,    cond: C_NEVER,     target: STEP_WAIT};
            STEP_OUT:    w = '{op: OP_OUT,       cond: C_OUT_MORE,  target: STEP_OUT};
            default:     w = '{op: OP_NOP,       cond: C_NEVER,     target: STEP_WAIT};
        endcase
        return w;
    endfunction

endpackage

// File: rtl/core/joystick_to_midi_conditioner.sv
// Joystick to MIDI conditioner. Each input beat is one millisecond tick carrying two 7-bit
// axis samples and the debounced button level. Every scan_period ticks both axes are scaled
// to controller values (axis 0 inverted), followed by note on/off on button edges; up to
// three message beats per tick, tlast on the final one, none when nothing changes. A small
// control program steps a shared 13-step restoring divider. An input beat is taken only when
// the previous tick's messages are all gone. A tick without a scan runs the wait, check,
// button and output steps; a scan adds the setup and next-axis steps for each axis, and the
// divider and push steps for an axis that sends. The output step is entered even when
// nothing is sent, and output stalls lengthen a tick. Configuration writes are taken in any
// cycle and belong in idle time.
module joystick_to_midi_conditioner (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input ticks
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [6:0] axis_x_sample, [13:7] axis_y_sample,
                                        // [14] button_level, [15] zero
    // messages
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [6:0] msg_number, [13:7] msg_value, [15:14] zero
    output logic [1:0]  m_axis_tuser,   // [1:0] msg_kind
    output logic        m_axis_tlast,
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    // configuration registers
    logic [6:0] r_center_x, r_center_y, r_cc_x, r_cc_y, r_note;
    logic [7:0] r_scan_period;

    // control state
    logic [jmc_pkg::STEP_W-1:0] r_pc, n_pc;
    logic       r_axis, n_axis;
    logic       r_scan, n_scan;
    logic [7:0] r_scan_cnt, n_scan_cnt;
    logic [6:0] r_last_x, n_last_x, r_last_y, n_last_y;
    logic       r_btn_prev, n_btn_prev;
    logic [3:0] r_div_cnt, n_div_cnt;
    logic [1:0] r_cnt, n_cnt, r_rd, n_rd;

    // datapath
    logic [6:0] r_sx, n_sx, r_sy, n_sy;
    logic       r_btn, n_btn;
    logic [jmc_pkg::NUM_W-1:0] r_num, n_num;
    logic [6:0] r_rem, n_rem, r_div, n_div, r_off, n_off;
    jmc_pkg::t_msg r_res [3];
    jmc_pkg::t_msg push_msg;
    logic          push_en;

    jmc_pkg::t_uword uw;
    logic in_acc, out_acc, cfg_acc, cond_hit, out_done;

    // setup decode
    logic [6:0] s_cur, c_cur, l_cur, c_comp, l_new, dlt;
    logic [jmc_pkg::NUM_W-1:0] setup_num;
    logic [6:0] setup_div, setup_off;
    logic       setup_send;

    // divider step and tick entry
    logic [7:0] rem_sh;
    logic       rem_ge;
    logic [7:0] cnt_inc;
    logic [6:0] cc_val;

    assign uw            = jmc_pkg::ucode(r_pc);
    assign s_axis_tready = (r_pc == jmc_pkg::STEP_WAIT);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (r_pc == jmc_pkg::STEP_OUT) && (r_rd != r_cnt);
    assign out_acc       = m_axis_tvalid && m_axis_tready;
    assign m_axis_tlast  = (r_rd == (r_cnt - 2'd1));
    assign m_axis_tdata  = {2'b00, r_res[r_rd].value, r_res[r_rd].number};
    assign m_axis_tuser  = r_res[r_rd].kind;
    assign o_cfg_ready   = 1'b1;
    assign cfg_acc       = i_cfg_valid && o_cfg_ready;
    assign out_done      = (r_rd == r_cnt) || (out_acc && m_axis_tlast);

    // axis scaling case selection
    always_comb begin
        s_cur      = r_axis ? r_sy : r_sx;
        c_cur      = r_axis ? r_center_y : r_center_x;
        l_cur      = r_axis ? r_last_y : r_last_x;
        c_comp     = jmc_pkg::FULL_SCALE - c_cur;
        l_new      = l_cur;
        dlt        = '0;
        setup_num  = '0;
        setup_div  = c_cur;
        setup_off  = '0;
        setup_send = 1'b0;
        if (s_cur == c_cur) begin
            if (l_cur > c_cur) begin
                l_new      = l_cur - 7'd1;
                dlt        = l_new - c_cur;
                setup_num  = {dlt, 6'b0};
                setup_div  = c_comp;
                setup_off  = jmc_pkg::OFFSET_RETURN;
                setup_send = 1'b1;
            end else if (l_cur < c_cur) begin
                l_new      = l_cur + 7'd1;
                setup_num  = {l_new, 6'b0} - {6'b0, l_new};
                setup_send = 1'b1;
            end
        end else if (({1'b0, s_cur} + jmc_pkg::DEAD_BAND) < {1'b0, c_cur}) begin
            l_new      = s_cur;
            setup_num  = {s_cur, 6'b0};
            setup_send = 1'b1;
        end else if ({1'b0, s_cur} > ({1'b0, c_cur} + jmc_pkg::DEAD_BAND)) begin
            l_new      = s_cur;
            dlt        = s_cur - c_cur;
            setup_num  = {dlt, 6'b0} - {5'b0, dlt, 1'b0};
            setup_div  = c_comp;
            setup_off  = jmc_pkg::OFFSET_HIGH;
            setup_send = 1'b1;
        end
    end

    // one restoring division step
    assign rem_sh  = {r_rem, r_num[jmc_pkg::NUM_W-1]};
    assign rem_ge  = (rem_sh >= {1'b0, r_div});
    assign cnt_inc = (r_scan_cnt == jmc_pkg::SCAN_CNT_MAX) ? r_scan_cnt : r_scan_cnt + 8'd1;
    assign cc_val  = r_num[6:0] + r_off;

    // condition select
    always_comb begin
        case (uw.cond)
            jmc_pkg::C_NEVER:     cond_hit = 1'b0;
            jmc_pkg::C_NO_INPUT:  cond_hit = !in_acc;
            jmc_pkg::C_NO_SCAN:   cond_hit = !r_scan;
            jmc_pkg::C_NO_SEND:   cond_hit = !setup_send;
            jmc_pkg::C_DIV_MORE:  cond_hit = (r_div_cnt != 4'd0);
            jmc_pkg::C_AXIS_ZERO: cond_hit = !r_axis;
            jmc_pkg::C_OUT_MORE:  cond_hit = !out_done;
            default:              cond_hit = 1'b0;
        endcase
    end

    // datapath operations per control word
    always_comb begin
        n_pc       = cond_hit ? uw.target : r_pc + 3'd1;
        n_axis     = r_axis;
        n_scan     = r_scan;
        n_scan_cnt = r_scan_cnt;
        n_last_x   = r_last_x;
        n_last_y   = r_last_y;
        n_btn_prev = r_btn_prev;
        n_div_cnt  = r_div_cnt;
        n_cnt      = r_cnt;
        n_rd       = r_rd;
        n_sx       = r_sx;
        n_sy       = r_sy;
        n_btn      = r_btn;
        n_num      = r_num;
        n_rem      = r_rem;
        n_div      = r_div;
        n_off      = r_off;
        push_en    = 1'b0;
        push_msg   = '{kind: jmc_pkg::KIND_CC, number: r_cc_x, value: cc_val};
        case (uw.op)
            jmc_pkg::OP_ACCEPT: begin
                if (in_acc) begin
                    n_sx   = s_axis_tdata[6:0];
                    n_sy   = s_axis_tdata[13:7];
                    n_btn  = s_axis_tdata[14];
                    n_axis = 1'b0;
                    n_cnt  = '0;
                    n_rd   = '0;
                    n_scan = (cnt_inc >= r_scan_period);
                    n_scan_cnt = (cnt_inc >= r_scan_period) ? 8'd0 : cnt_inc;
                end
            end
            jmc_pkg::OP_SETUP: begin
                n_num     = setup_num;
                n_div     = setup_div;
                n_off     = setup_off;
                n_rem     = '0;
                n_div_cnt = jmc_pkg::DIV_LAST_STEP;
                if (r_axis) n_last_y = l_new;
                else        n_last_x = l_new;
            end
            jmc_pkg::OP_DIV: begin
                n_rem     = rem_ge ? 7'(rem_sh - {1'b0, r_div}) : rem_sh[6:0];
                n_num     = {r_num[jmc_pkg::NUM_W-2:0], rem_ge};
                n_div_cnt = r_div_cnt - 4'd1;
            end
            jmc_pkg::OP_PUSH_CC: begin
                push_en  = 1'b1;
                push_msg = r_axis
                    ? '{kind: jmc_pkg::KIND_CC, number: r_cc_y, value: cc_val}
                    : '{kind: jmc_pkg::KIND_CC, number: r_cc_x, value: ~cc_val};
                n_cnt    = r_cnt + 2'd1;
            end
            jmc_pkg::OP_NEXT_AXIS: begin
                n_axis = 1'b1;
            end
            jmc_pkg::OP_BUTTON: begin
                if (r_btn_prev && !r_btn) begin
                    push_en  = 1'b1;
                    push_msg = '{kind: jmc_pkg::KIND_NOTE_ON, number: r_note,
                                 value: jmc_pkg::VELOCITY_ON};
                    n_cnt    = r_cnt + 2'd1;
                end else if (!r_btn_prev && r_btn) begin
                    push_en  = 1'b1;
                    push_msg = '{kind: jmc_pkg::KIND_NOTE_OFF, number: r_note,
                                 value: jmc_pkg::VELOCITY_OFF};
                    n_cnt    = r_cnt + 2'd1;
                end
                n_btn_prev = r_btn;
            end
            jmc_pkg::OP_OUT: begin
                if (out_acc) n_rd = r_rd + 2'd1;
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc       <= jmc_pkg::STEP_WAIT;
            r_axis     <= 1'b0;
            r_scan     <= 1'b0;
            r_scan_cnt <= '0;
            r_last_x   <= '0;
            r_last_y   <= '0;
            r_btn_prev <= 1'b1;
            r_div_cnt  <= '0;
            r_cnt      <= '0;
            r_rd       <= '0;
        end else begin
            r_pc       <= n_pc;
            r_axis     <= n_axis;
            r_scan     <= n_scan;
            r_scan_cnt <= n_scan_cnt;
            r_last_x   <= n_last_x;
            r_last_y   <= n_last_y;
            r_btn_prev <= n_btn_prev;
            r_div_cnt  <= n_div_cnt;
            r_cnt      <= n_cnt;
            r_rd       <= n_rd;
        end
    end

    // payload registers and message buffer
    always_ff @(posedge i_clk) begin
        r_sx  <= n_sx;
        r_sy  <= n_sy;
        r_btn <= n_btn;
        r_num <= n_num;
        r_rem <= n_rem;
        r_div <= n_div;
        r_off <= n_off;
        if (push_en) r_res[r_cnt] <= push_msg;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x    <= jmc_pkg::RST_CENTER_X;
            r_center_y    <= jmc_pkg::RST_CENTER_Y;
            r_cc_x        <= jmc_pkg::RST_CC_NUMBER_X;
            r_cc_y        <= jmc_pkg::RST_CC_NUMBER_Y;
            r_note        <= jmc_pkg::RST_NOTE_NUMBER;
            r_scan_period <= jmc_pkg::RST_SCAN_PERIOD;
        end else if (cfg_acc) begin
            case (i_cfg_index)
                jmc_pkg::CFG_CENTER_X:    r_center_x    <= i_cfg_data[6:0];
                jmc_pkg::CFG_CENTER_Y:    r_center_y    <= i_cfg_data[6:0];
                jmc_pkg::CFG_CC_NUMBER_X: r_cc_x        <= i_cfg_data[6:0];
                jmc_pkg::CFG_CC_NUMBER_Y: r_cc_y        <= i_cfg_data[6:0];
                jmc_pkg::CFG_NOTE_NUMBER: r_note        <= i_cfg_data[6:0];
                jmc_pkg::CFG_SCAN_PERIOD: r_scan_period <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

// File: rtl/core/jmc_checker.sv
module jmc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // a tick is not taken while its predecessor still has messages out
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input taken while messages pending");

    // an accepted tick is worked on before the next one is taken
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input ready right after accept");

    // the final beat of a tick hands back to the input side
    a_last_ends_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=>
            (s_axis_tready && !m_axis_tvalid))
        else $error("tick not closed after last beat");

    // note on messages carry the fixed on velocity
    a_note_velocity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == jmc_pkg::KIND_NOTE_ON) |->
            (m_axis_tdata[13:7] == jmc_pkg::VELOCITY_ON))
        else $error("note on velocity wrong");

    // a stalled message holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
             && $stable(m_axis_tlast)))
        else $error("stalled message changed");

endmodule

bind joystick_to_midi_conditioner jmc_checker u_jmc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// File: tb/tb_top.sv
module tb_top;

    import jmc_pkg::*;

    // Register indexes the block does not decode
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

    // Row marker: the expectation comes from the predictor, not from the table
    localparam int PREDICTED = -1;

    // A tick with no result may keep the block busy after the pending queue has emptied
    localparam int DRAIN_CYCLES = 50;
    localparam int HOLD_OFF_CYCLES = 400;
    // ~270 ticks with their stalled message beats, plus drains and the hold-off
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic [1:0] kind;
        logic [6:0] number;
        logic [6:0] value;
        logic       last;
    } midi_beat_t;

    typedef struct {
        bit                   is_reg;
        logic [CFG_IDX_W-1:0] idx;
        logic [7:0]           wdata;
        logic [6:0]           x;
        logic [6:0]           y;
        logic                 btn;
        int                   typed;
        logic [1:0]           kind;
        logic [6:0]           number;
        logic [6:0]           value;
    } stim_row_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // [6:0] axis_x_sample, [13:7] axis_y_sample,
                                 // [14] button_level, [15] zero
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // [6:0] msg_number, [13:7] msg_value, [15:14] zero
    logic [1:0]  m_axis_tuser;   // [1:0] msg_kind
    logic        m_axis_tlast;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [7:0]  i_cfg_data;

    joystick_to_midi_conditioner dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // Predictor copy of the registers and the tick state
    logic [6:0] rest_x     = RST_CENTER_X;
    logic [6:0] rest_y     = RST_CENTER_Y;
    logic [6:0] cc_x       = RST_CC_NUMBER_X;
    logic [6:0] cc_y       = RST_CC_NUMBER_Y;
    logic [6:0] note_num   = RST_NOTE_NUMBER;
    logic [7:0] scan_every = RST_SCAN_PERIOD;
    logic [7:0] scan_cnt   = '0;
    logic [6:0] sent_x     = '0;
    logic [6:0] sent_y     = '0;
    logic       btn_prev   = 1'b1;

    midi_beat_t pending[$];
    stim_row_t  dir_rows[$];
    int         err_cnt = 0;
    int         cycle_cnt = 0;
    int         tx_idle_pct = 0;
    int         rx_idle_pct = 0;
    int         rx_hold_len = 0;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("tb_top: done, errors");
        $finish;
    end

    // Scale one axis sample; moves the remembered position, returns 1 when a value goes out
    function automatic logic axis_scale(input int s, input int c, inout logic [6:0] pos,
                                        output logic [6:0] val);
        int p;
        p = pos;
        val = '0;
        if (s == c) begin
            // at rest: walk the last sent position one step back to center
            if (p > c) begin
                p = p - 1;
                pos = 7'(p);
                val = 7'((p - c) * 64 / (127 - c) + 63);
                return 1'b1;
            end
            if (p < c) begin
                p = p + 1;
                pos = 7'(p);
                val = 7'(p * 63 / c);
                return 1'b1;
            end
            return 1'b0;
        end
        if (s + 2 < c) begin
            val = 7'(s * 64 / c);
            pos = 7'(s);
            return 1'b1;
        end
        if (s > c + 2) begin
            val = 7'((s - c) * 62 / (127 - c) + 65);
            pos = 7'(s);
            return 1'b1;
        end
        // inside the dead band
        return 1'b0;
    endfunction

    function automatic void queue_msg(input logic [1:0] kind, input logic [6:0] number,
                                      input logic [6:0] value);
        midi_beat_t m;
        m.kind   = kind;
        m.number = number;
        m.value  = value;
        m.last   = 1'b0;
        pending.push_back(m);
    endfunction

    // Messages caused by one tick, appended to the pending queue
    function automatic int midi_for_tick(input logic [6:0] x, input logic [6:0] y,
                                         input logic b);
        logic [6:0] v;
        int n;
        n = 0;
        if (scan_cnt != SCAN_CNT_MAX)
            scan_cnt++;
        if (scan_cnt >= scan_every) begin
            if (axis_scale(x, rest_x, sent_x, v)) begin
                queue_msg(KIND_CC, cc_x, 7'(127 - v));
                n++;
            end
            if (axis_scale(y, rest_y, sent_y, v)) begin
                queue_msg(KIND_CC, cc_y, v);
                n++;
            end
            scan_cnt = '0;
        end
        if (btn_prev && !b) begin
            queue_msg(KIND_NOTE_ON, note_num, VELOCITY_ON);
            n++;
        end else if (!btn_prev && b) begin
            queue_msg(KIND_NOTE_OFF, note_num, VELOCITY_OFF);
            n++;
        end
        btn_prev = b;
        if (n > 0)
            pending[pending.size()-1].last = 1'b1;
        return n;
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] d);
        case (idx)
            CFG_CENTER_X:    rest_x = d[6:0];
            CFG_CENTER_Y:    rest_y = d[6:0];
            CFG_CC_NUMBER_X: cc_x = d[6:0];
            CFG_CC_NUMBER_Y: cc_y = d[6:0];
            CFG_NOTE_NUMBER: note_num = d[6:0];
            CFG_SCAN_PERIOD: scan_every = d;
            default: ;
        endcase
    endfunction

    function automatic stim_row_t tick_row(input int x, input int y, input int b, input int typed,
                                           input logic [1:0] kind, input int number,
                                           input int value);
        stim_row_t r;
        r.is_reg = 1'b0;
        r.idx    = '0;
        r.wdata  = '0;
        r.x      = 7'(x);
        r.y      = 7'(y);
        r.btn    = 1'(b);
        r.typed  = typed;
        r.kind   = kind;
        r.number = 7'(number);
        r.value  = 7'(value);
        return r;
    endfunction

    function automatic stim_row_t reg_row(input logic [CFG_IDX_W-1:0] idx, input int d);
        stim_row_t r;
        r = tick_row(0, 0, 0, PREDICTED, KIND_CC, 0, 0);
        r.is_reg = 1'b1;
        r.idx    = idx;
        r.wdata  = 8'(d);
        return r;
    endfunction

    // Mostly at or near the rest position, so the return-to-center walk gets exercised
    function automatic logic [6:0] pick_sample(input logic [6:0] c);
        int r;
        int v;
        r = $urandom_range(0, 99);
        if (r < 30)
            return c;
        if (r < 60) begin
            v = int'(c) + int'($urandom_range(0, 8)) - 4;
            if (v >= 0 && v <= 127)
                return 7'(v);
        end
        if (r < 72)
            return $urandom_range(0, 1) ? 7'd127 : 7'd0;
        return 7'($urandom_range(0, 127));
    endfunction

    function automatic logic [7:0] pick_center();
        logic [6:0] v;
        case ($urandom_range(0, 7))
            0: v = 7'd0;
            1: v = 7'd127;
            2: v = 7'd3;
            3: v = 7'd124;
            default: v = 7'($urandom_range(0, 127));
        endcase
        // bit 7 is dropped by the 7-bit registers
        return {1'($urandom_range(0, 1)), v};
    endfunction

    // Send one tick beat; leaves tvalid high, returns how many messages it should cause
    task automatic send_tick(input logic [6:0] x, input logic [6:0] y, input logic b,
                             output int n);
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(0, 99) < tx_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, b, y, x};
        do @(posedge i_clk); while (!s_axis_tready);
        n = midi_for_tick(x, y, b);
        @(negedge i_clk);
    endtask

    // Stop sending and wait until the block has gone idle
    task automatic quiesce();
        s_axis_tvalid <= 1'b0;
        while (pending.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // One register write; leaves valid high for a following write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_reg(idx, d);
        @(negedge i_clk);
    endtask

    // Receiver: random tready, or a long hold-off when asked
    initial begin
        int n;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_len > 0) begin
                n = rx_hold_len;
                rx_hold_len = 0;
                m_axis_tready <= 1'b0;
                repeat (n) @(negedge i_clk);
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // Message checker
    always @(posedge i_clk) begin
        midi_beat_t e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending.size() == 0) begin
                $error("unexpected message beat: kind %0d number %0d value %0d",
                       m_axis_tuser, m_axis_tdata[6:0], m_axis_tdata[13:7]);
                err_cnt++;
            end else begin
                e = pending.pop_front();
                if (m_axis_tuser !== e.kind) begin
                    $error("msg_kind: expected %0d, actual %0d", e.kind, m_axis_tuser);
                    err_cnt++;
                end
                if (m_axis_tdata[6:0] !== e.number) begin
                    $error("msg_number: expected %0d, actual %0d", e.number, m_axis_tdata[6:0]);
                    err_cnt++;
                end
                if (m_axis_tdata[13:7] !== e.value) begin
                    $error("msg_value: expected %0d, actual %0d", e.value, m_axis_tdata[13:7]);
                    err_cnt++;
                end
                if (m_axis_tlast !== e.last) begin
                    $error("last: expected %0d, actual %0d", e.last, m_axis_tlast);
                    err_cnt++;
                end
            end
        end
    end

    // Stimulus
    initial begin
        stim_row_t  r;
        int         n;
        int         items;
        int         run_left;
        bit         cfg_open;
        logic [6:0] x;
        logic [6:0] y;
        logic       b;

        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        i_rst_n       = 1'b0;

        // Directed table: x, y, button, typed count (or predicted), kind, number, value
        // reset settings, scan every 5 ticks: only the button speaks until the fifth tick
        dir_rows.push_back(tick_row(64, 64, 0, 1, KIND_NOTE_ON, 60, 127));
        dir_rows.push_back(tick_row(127, 0, 1, 1, KIND_NOTE_OFF, 60, 0));
        dir_rows.push_back(tick_row(0, 127, 1, 0, KIND_CC, 0, 0));
        dir_rows.push_back(tick_row(0, 127, 1, 0, KIND_CC, 0, 0));
        dir_rows.push_back(tick_row(0, 127, 1, PREDICTED, KIND_CC, 0, 0));
        // zero scan period: scan on every tick
        dir_rows.push_back(reg_row(CFG_SCAN_PERIOD, 0));
        dir_rows.push_back(tick_row(64, 64, 1, PREDICTED, KIND_CC, 0, 0));
        dir_rows.push_back(tick_row(61, 67, 1, PREDICTED, KIND_CC, 0, 0));
        // dead band edges send nothing
        dir_rows.push_back(tick_row(62, 66, 0, 1, KIND_NOTE_ON, 60, 127));
        dir_rows.push_back(tick_row(63, 65, 0, 0, KIND_CC, 0, 0));
        // walk back to center from both sides, three beats on the press release
        dir_rows.push_back(tick_row(64, 64, 0, PREDICTED, KIND_CC, 0, 0));
        dir_rows.push_back(tick_row(64, 64, 1, PREDICTED, KIND_CC, 0, 0));
        dir_rows.push_back(tick_row(64, 64, 1, PREDICTED, KIND_CC, 0, 0));
        dir_rows.push_back(tick_row(64, 64, 1, 0, KIND_CC, 0, 0));
        // extreme centers and numbers, bit 7 on a 7-bit register, unknown indexes ignored
        dir_rows.push_back(reg_row(CFG_CENTER_X, 0));
        dir_rows.push_back(reg_row(CFG_CENTER_Y, 127));
        dir_rows.push_back(reg_row(CFG_CC_NUMBER_X, 127));
        dir_rows.push_back(reg_row(CFG_CC_NUMBER_Y, 8'h80));
        dir_rows.push_back(reg_row(CFG_NOTE_NUMBER, 127));
        dir_rows.push_back(reg_row(CFG_SPARE_A, 8'hff));
        dir_rows.push_back(reg_row(CFG_SPARE_B, 8'h01));
        dir_rows.push_back(tick_row(0, 127, 0, PREDICTED, KIND_CC, 0, 0));
        dir_rows.push_back(tick_row(127, 0, 1, PREDICTED, KIND_CC, 0, 0));
        dir_rows.push_back(tick_row(1, 126, 1, 0, KIND_CC, 0, 0));
        dir_rows.push_back(tick_row(2, 125, 1, 0, KIND_CC, 0, 0));
        dir_rows.push_back(tick_row(3, 124, 0, PREDICTED, KIND_CC, 0, 0));
        // longest scan period: no scan for the next ticks
        dir_rows.push_back(reg_row(CFG_SCAN_PERIOD, 255));
        dir_rows.push_back(reg_row(CFG_CENTER_X, 124));
        dir_rows.push_back(reg_row(CFG_CENTER_Y, 3));
        dir_rows.push_back(tick_row(0, 127, 1, 1, KIND_NOTE_OFF, 127, 0));
        dir_rows.push_back(tick_row(127, 0, 1, 0, KIND_CC, 0, 0));

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        tx_idle_pct = 14;
        rx_idle_pct = 58;

        // Walk the directed table
        cfg_open = 1'b0;
        for (int i = 0; i < dir_rows.size(); i++) begin
            r = dir_rows[i];
            if (r.is_reg) begin
                if (!cfg_open) begin
                    quiesce();
                    cfg_open = 1'b1;
                end
                write_reg(r.idx, r.wdata);
            end else begin
                if (cfg_open) begin
                    i_cfg_valid <= 1'b0;
                    cfg_open = 1'b0;
                end
                send_tick(r.x, r.y, r.btn, n);
                if (r.typed != PREDICTED) begin
                    repeat (n) void'(pending.pop_back());
                    if (r.typed == 1) begin
                        queue_msg(r.kind, r.number, r.value);
                        pending[pending.size()-1].last = 1'b1;
                    end
                end
            end
        end

        // Random phases: new settings each time, ticks held in short runs
        b = 1'b1;
        for (int p = 0; p < 9; p++) begin
            if (p == 3) begin
                tx_idle_pct = 58;
                rx_idle_pct = 14;
            end else if (p == 6) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            quiesce();
            write_reg(CFG_CENTER_X, pick_center());
            write_reg(CFG_CENTER_Y, pick_center());
            write_reg(CFG_CC_NUMBER_X, 8'($urandom_range(0, 255)));
            write_reg(CFG_CC_NUMBER_Y, 8'($urandom_range(0, 255)));
            write_reg(CFG_NOTE_NUMBER, 8'($urandom_range(0, 255)));
            case (p)
                1, 6:    write_reg(CFG_SCAN_PERIOD, 8'd0);
                3:       write_reg(CFG_SCAN_PERIOD, 8'd255);
                7:       write_reg(CFG_SCAN_PERIOD, 8'd1);
                default: write_reg(CFG_SCAN_PERIOD, 8'($urandom_range(1, 4)));
            endcase
            if ($urandom_range(0, 1))
                write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B,
                          8'($urandom_range(0, 255)));
            i_cfg_valid <= 1'b0;

            items = (p == 3) ? 20 : 29;
            run_left = 0;
            for (int k = 0; k < items; k++) begin
                if (run_left == 0) begin
                    x = pick_sample(rest_x);
                    y = pick_sample(rest_y);
                    run_left = $urandom_range(1, 6);
                end
                run_left--;
                if ($urandom_range(0, 99) < 30)
                    b = ~b;
                // receiver backs off for a long stretch while ticks keep coming
                if (p == 1 && k == 10)
                    rx_hold_len = HOLD_OFF_CYCLES;
                // sender stops until every pending message is out
                if (p == 4 && k == 15) begin
                    s_axis_tvalid <= 1'b0;
                    while (pending.size() != 0)
                        @(negedge i_clk);
                end
                send_tick(x, y, b, n);
            end
        end

        // Drain and let the block settle
        s_axis_tvalid <= 1'b0;
        while (pending.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (err_cnt == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
